FILE: design/double_ended_queue_engine_top_assert.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(label, clk, rst, prop, msg)
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LIST_FWD   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_LIST_BWD   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic                push_back;
    logic                push_front;
    logic                pop_front;
    logic                pop_back;
    logic                list_start;
    logic                list_bwd;
    logic                step;
    logic                load_status;
    logic [STATUS_W-1:0] status_code;
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
    logic out_free;
  } deq_stat_t;

endpackage

`default_nettype wire

FILE: design/deq_ram.sv
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/deq_dp.sv
`default_nettype none

`include "double_ended_queue_engine_top_assert.svh"

module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire deq_pkg::deq_cmd_t              cmd,
  output deq_pkg::deq_stat_t                  stat,
  input  wire logic signed [deq_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [deq_pkg::DATA_W-1:0]   item,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic                                last
);

  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [AW-1:0] walk_ptr;
  logic [CW-1:0] remaining;
  logic          walk_bwd;

  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail_pos;
  logic [AW-1:0]     back_pos;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [AW-1:0]     walk_next;
  logic [AW-1:0]     list_first;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    ring_dec = (p == '0) ? LAST_POS : p - AW'(1);
  endfunction

  // front + count stays below twice the depth: one compare and subtract wraps it
  assign tail_sum   = SW'(front) + SW'(count);
  assign tail_pos   = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign back_pos   = ring_dec(tail_pos);
  assign front_dec  = ring_dec(front);
  assign front_inc  = ring_inc(front);
  assign walk_next  = walk_bwd ? ring_dec(walk_ptr) : ring_inc(walk_ptr);
  assign list_first = cmd.list_bwd ? back_pos : front;

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.walk_last = (remaining == CW'(1));
  assign stat.out_free  = !out_valid || out_ready;

  assign wr_en   = cmd.push_back || cmd.push_front;
  assign wr_addr = cmd.push_front ? front_dec : tail_pos;

  assign rd_en = cmd.pop_front || cmd.pop_back || cmd.list_start ||
                 (cmd.step && !stat.walk_last);

  always_comb begin
    rd_addr = walk_next;
    if (cmd.pop_front) begin
      rd_addr = front;
    end else if (cmd.pop_back) begin
      rd_addr = back_pos;
    end else if (cmd.list_start) begin
      rd_addr = list_first;
    end
  end

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (cmd.push_back) begin
        count <= count + CW'(1);
      end else if (cmd.push_front) begin
        front <= front_dec;
        count <= count + CW'(1);
      end else if (cmd.pop_front) begin
        front <= front_inc;
        count <= count - CW'(1);
      end else if (cmd.pop_back) begin
        count <= count - CW'(1);
      end
    end
  end

  // Walk over the ring; a pop is a walk of one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      walk_ptr  <= '0;
      walk_bwd  <= 1'b0;
    end else begin
      if (cmd.list_start) begin
        remaining <= count;
        walk_ptr  <= list_first;
        walk_bwd  <= cmd.list_bwd;
      end else if (cmd.pop_front || cmd.pop_back) begin
        remaining <= CW'(1);
      end else if (cmd.step) begin
        remaining <= remaining - CW'(1);
        walk_ptr  <= walk_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      item   <= '0;
      status <= cmd.status_code;
      last   <= 1'b1;
    end else if (cmd.step) begin
      item   <= rd_data;
      status <= ST_OK;
      last   <= stat.walk_last;
    end
  end

  `DEQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "entry count beyond depth")
  `DEQ_ASSERT(a_front_range, clk, rst, front <= LAST_POS, "front index outside the ring")
  `DEQ_ASSERT(a_port_clash, clk, rst, !(wr_en && rd_en), "store written and read together")
  `DEQ_ASSERT(a_no_overwrite, clk, rst, (cmd.load_status || cmd.step) |-> stat.out_free, "result loaded over a waiting one")

endmodule

`default_nettype wire

FILE: design/deq_ctrl.sv
`default_nettype none

`include "double_ended_queue_engine_top_assert.svh"

module deq_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [deq_pkg::ACTION_W-1:0]     action,
  input  wire deq_pkg::deq_stat_t               stat,
  output deq_pkg::deq_cmd_t                     cmd
);

  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action) inside
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
              cmd.load_status = 1'b1;
              if (stat.full) begin
                cmd.status_code = ST_FULL;
              end else begin
                cmd.status_code = ST_OK;
                cmd.push_back   = (action == ACT_PUSH_BACK);
                cmd.push_front  = (action == ACT_PUSH_FRONT);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (stat.empty) begin
                cmd.load_status = 1'b1;
                cmd.status_code = ST_EMPTY;
              end else begin
                cmd.pop_front = (action == ACT_POP_FRONT);
                cmd.pop_back  = (action == ACT_POP_BACK);
                state_next    = S_FETCH;
              end
            end
            ACT_LIST_FWD, ACT_LIST_BWD: begin
              if (stat.empty) begin
                cmd.load_status = 1'b1;
                cmd.status_code = ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                cmd.list_bwd   = (action == ACT_LIST_BWD);
                state_next     = S_FETCH;
              end
            end
            default: ; // drop unused action codes
          endcase
        end
      end
      S_FETCH: begin
        // emit the fetched entry once the output slot frees
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.walk_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DEQ_ASSERT(a_fetch_blocks, clk, rst, (state == S_FETCH) |-> !in_ready, "request taken during a fetch")
  `DEQ_ASSERT(a_pop_fetch, clk, rst, (accept && !stat.empty && (action == ACT_POP_FRONT || action == ACT_POP_BACK)) |=> (state == S_FETCH), "pop did not enter fetch")
  `DEQ_ASSERT(a_walk_done, clk, rst, (state == S_FETCH && stat.out_free && stat.walk_last) |=> (state == S_IDLE), "walk overran its last entry")

endmodule

`default_nettype wire

FILE: design/double_ended_queue_engine_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_ready  action[2:0], value[31:0] signed
// out      out_valid/out_ready  item[31:0] signed, status[1:0], last
//
// Push, and any request that is refused or meets an empty queue: result in the cycle after
// acceptance. Pop: the registered store read is followed by the load of the output register.
// A listing of N entries emits one entry per cycle while out_ready is held high.
// One request at a time: the next is taken once the controller is idle and the output
// register is empty or being drained. A stalled out_ready holds the walk in place.
// rst (synchronous) empties the queue; stored values are not cleared.
`default_nettype none

module double_ended_queue_engine_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [deq_pkg::ACTION_W-1:0]        action,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [deq_pkg::DATA_W-1:0]        item,
  output logic [deq_pkg::STATUS_W-1:0]             status,
  output logic                                     last
);

  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action  (action),
    .stat    (stat),
    .cmd     (cmd)
  );

  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .item     (item),
    .status   (status),
    .last     (last)
  );

endmodule

`default_nettype wire
